@@ src/luma_key_mixer_core_defines.svh @@
// Assertion macros for the luma key mixer core.
// Used by luma_key_mixer_core.sv; expects clk and rst_n in the including scope.
`ifndef LUMA_KEY_MIXER_CORE_DEFINES_SVH
`define LUMA_KEY_MIXER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define LKM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("luma key mixer: check failed");
// Antecedent implies consequent, delayed by the dly argument.
`define LKM_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("luma key mixer: latency check failed");
`else
`define LKM_ASSERT_IMPLY(label, ante, cons)
`define LKM_ASSERT_DELAY(label, ante, dly, cons)
`endif
`endif

@@ src/lkm_pkg.sv @@
// Types and constants shared by the luma key mixer core.
// No dependencies; used by luma_key_mixer_core.sv.
package lkm_pkg;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OPACITY        = 3'd0,
        REG_LOW_THRESHOLD  = 3'd1,
        REG_HIGH_THRESHOLD = 3'd2,
        REG_SOFTNESS       = 3'd3,
        REG_INVERT_KEY     = 3'd4
    } cfg_reg_t;

    // Register reset values.
    localparam logic [7:0] OPACITY_RESET        = 8'd255;
    localparam logic [7:0] LOW_THRESHOLD_RESET  = 8'd0;
    localparam logic [7:0] HIGH_THRESHOLD_RESET = 8'd50;
    localparam logic [7:0] SOFTNESS_RESET       = 8'd20;
    localparam logic       INVERT_KEY_RESET     = 1'b0;

    // Arithmetic constants.
    localparam logic [7:0]  ALPHA_MAX    = 8'd255;
    localparam logic [8:0]  WEIGHT_ONE   = 9'd256;
    localparam logic [23:0] WEIGHT_ROUND = 24'd32512;
    localparam logic [16:0] WEIGHT_DIV   = 17'd65025;
    // 2^32 / 65025 is approximated from below by 2^16 + 515.
    localparam logic [9:0]  RECIP_LOW    = 10'd515;
    localparam logic [16:0] MIX_ROUND    = 17'd128;

    // Where the foreground luma falls relative to the key window.
    typedef enum logic [1:0] {
        REGION_INSIDE,
        REGION_LOW_RAMP,
        REGION_HIGH_RAMP,
        REGION_OUTSIDE
    } key_region_t;

    // One input pixel pair.
    typedef struct packed {
        logic [7:0] fg_luma;
        logic [7:0] fg_blue_diff;
        logic [7:0] fg_red_diff;
        logic [7:0] bg_luma;
        logic [7:0] bg_blue_diff;
        logic [7:0] bg_red_diff;
    } pixel_t;

    // One mixed output pixel.
    typedef struct packed {
        logic [7:0] out_luma;
        logic [7:0] out_blue_diff;
        logic [7:0] out_red_diff;
    } result_t;

endpackage

@@ src/luma_key_mixer_core.sv @@
// Luma key mixer core: soft luma key, opacity weight and three-component blend.
// Depends on lkm_pkg and luma_key_mixer_core_defines.svh.
//
// Usage:
//   A pixel pair is taken on pixel at any rising edge where start is high and
//   busy is low. busy stays low, so one pixel pair can enter every clock.
//   The mixed pixel appears on result with done high for exactly one cycle,
//   as it leaves the blend stage. Results leave in the order the pixels
//   entered.
//   Throughput is one pixel per clock; each pixel passes through 19 pipeline
//   stages: the input register, key classification, the ramp numerator, eight
//   one-bit stages of the restoring divider for the ramp, alpha, the opacity
//   product, five stages of the reciprocal division by 65025, and the blend.
//   The receiver cannot stall the block; a result is gone after its cycle.
//   Registers are written over cfg_valid/cfg_ready/cfg_index/cfg_data;
//   cfg_ready is always high and indexes past the list are ignored. Write
//   registers only while no pixel is in flight.
//   Reset (rst_n low) empties the pipeline and restores register defaults:
//   opacity 255, thresholds 0 and 50, softness 20, no key inversion.
`include "luma_key_mixer_core_defines.svh"

module luma_key_mixer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  lkm_pkg::pixel_t                     pixel,
    output logic                                done,
    output lkm_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lkm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lkm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Stage numbering of the pipeline.
    localparam int ST_CLASS   = 1;
    localparam int ST_NUM     = 2;
    localparam int DIV_STEPS  = 8;
    localparam int ST_DIV0    = 3;
    localparam int ST_ALPHA   = ST_DIV0 + DIV_STEPS;
    localparam int ST_PROD    = ST_ALPHA + 1;
    localparam int ST_X       = ST_PROD + 1;
    localparam int ST_XM      = ST_X + 1;
    localparam int ST_QEST    = ST_XM + 1;
    localparam int ST_REM     = ST_QEST + 1;
    localparam int ST_WEIGHT  = ST_REM + 1;
    localparam int ST_MIX     = ST_WEIGHT + 1;
    localparam int NUM_STAGES = ST_MIX + 1;
    localparam int LATENCY    = NUM_STAGES;

    // Configuration registers.
    logic [7:0] opacity_reg;
    logic [7:0] low_thr_reg;
    logic [7:0] high_thr_reg;
    logic [7:0] softness_reg;
    logic       invert_reg;

    // Pipeline control and payload.
    logic                   accept;
    logic [NUM_STAGES-1:0]  valid_reg;
    lkm_pkg::pixel_t        pix_reg [0:NUM_STAGES-2];
    logic                   div_in_ramp;

    // Per-stage data registers.
    lkm_pkg::key_region_t   region1_reg;
    logic [7:0]             dist_reg;
    lkm_pkg::key_region_t   region2_reg;
    logic [16:0]            num_reg;
    lkm_pkg::key_region_t   div_region_reg [0:DIV_STEPS-1];
    logic [16:0]            div_rem_reg    [0:DIV_STEPS-1];
    logic [7:0]             div_quo_reg    [0:DIV_STEPS-1];
    logic [7:0]             alpha_reg;
    logic [15:0]            prod_reg;
    logic [23:0]            x_reg;
    logic [23:0]            x2_reg;
    logic [33:0]            xm_reg;
    logic [23:0]            x3_reg;
    logic [8:0]             qest_reg;
    logic [8:0]             q4_reg;
    logic [16:0]            rem_w_reg;
    logic [8:0]             weight_reg;
    lkm_pkg::result_t       result_reg;

    // Next values.
    logic [7:0]             thr_min;
    logic [7:0]             thr_max;
    lkm_pkg::key_region_t   region_next;
    logic [7:0]             dist_next;
    logic [16:0]            num_next;
    logic [7:0]             alpha_next;
    logic [15:0]            prod_next;
    logic [23:0]            x_next;
    logic [33:0]            xm_next;
    logic [8:0]             qest_next;
    logic [16:0]            rem_w_next;
    logic [8:0]             weight_next;
    lkm_pkg::result_t       result_next;

    // The block never pushes back on either channel.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign done      = valid_reg[ST_MIX];
    assign result    = result_reg;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg  <= lkm_pkg::OPACITY_RESET;
            low_thr_reg  <= lkm_pkg::LOW_THRESHOLD_RESET;
            high_thr_reg <= lkm_pkg::HIGH_THRESHOLD_RESET;
            softness_reg <= lkm_pkg::SOFTNESS_RESET;
            invert_reg   <= lkm_pkg::INVERT_KEY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lkm_pkg::REG_OPACITY:        opacity_reg  <= cfg_data;
                lkm_pkg::REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data;
                lkm_pkg::REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                lkm_pkg::REG_SOFTNESS:       softness_reg <= cfg_data;
                lkm_pkg::REG_INVERT_KEY:     invert_reg   <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // Valid bits travel down the pipeline with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[NUM_STAGES-2:0], accept};
        end
    end

    // Pixel payload shift line.
    always_ff @(posedge clk)
    begin
        pix_reg[0] <= pixel;
        for (int i = 1; i < NUM_STAGES - 1; i++)
        begin
            pix_reg[i] <= pix_reg[i-1];
        end
    end

    // Stage 1: classify the foreground luma against the ordered window.
    always_comb
    begin
        logic [7:0] y;
        y = pix_reg[0].fg_luma;
        thr_min = (low_thr_reg < high_thr_reg) ? low_thr_reg : high_thr_reg;
        thr_max = (low_thr_reg < high_thr_reg) ? high_thr_reg : low_thr_reg;
        dist_next = 8'(y - thr_max);
        if (y >= thr_min && y <= thr_max)
        begin
            region_next = lkm_pkg::REGION_INSIDE;
        end
        else if (softness_reg != 8'd0 && y < thr_min &&
                 (9'(y) + 9'(softness_reg)) >= 9'(thr_min))
        begin
            region_next = lkm_pkg::REGION_LOW_RAMP;
            dist_next   = 8'(9'(y) + 9'(softness_reg) - 9'(thr_min));
        end
        else if (softness_reg != 8'd0 && y > thr_max &&
                 9'(y) <= (9'(thr_max) + 9'(softness_reg)))
        begin
            region_next = lkm_pkg::REGION_HIGH_RAMP;
        end
        else
        begin
            region_next = lkm_pkg::REGION_OUTSIDE;
        end
    end

    // Stage 2: ramp numerator dist * 255 + softness / 2.
    assign num_next = (17'(dist_reg) << 8) - 17'(dist_reg) + 17'(softness_reg >> 1);

    always_ff @(posedge clk)
    begin
        region1_reg <= region_next;
        dist_reg    <= dist_next;
        region2_reg <= region1_reg;
        num_reg     <= num_next;
    end

    // Stages 3 to 10: restoring divider by softness, one quotient bit a stage.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        logic [16:0]          rem_in;
        logic [7:0]           quo_in;
        lkm_pkg::key_region_t region_in;
        logic [16:0]          div_shift;
        logic [16:0]          rem_next;
        logic [7:0]           quo_next;

        if (g == 0) begin : g_first
            assign rem_in    = num_reg;
            assign quo_in    = '0;
            assign region_in = region2_reg;
        end
        else begin : g_rest
            assign rem_in    = div_rem_reg[g-1];
            assign quo_in    = div_quo_reg[g-1];
            assign region_in = div_region_reg[g-1];
        end

        // Compare against softness shifted to this bit and subtract on a hit.
        always_comb
        begin
            div_shift = 17'(softness_reg) << (DIV_STEPS - 1 - g);
            rem_next  = rem_in;
            quo_next  = quo_in;
            if (rem_in >= div_shift)
            begin
                rem_next = rem_in - div_shift;
                quo_next[DIV_STEPS-1-g] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            div_rem_reg[g]    <= rem_next;
            div_quo_reg[g]    <= quo_next;
            div_region_reg[g] <= region_in;
        end
    end

    // Stage 11: alpha from region and ramp quotient, then optional inversion.
    always_comb
    begin
        logic [7:0] quo;
        quo = div_quo_reg[DIV_STEPS-1];
        case (div_region_reg[DIV_STEPS-1])
            lkm_pkg::REGION_INSIDE:    alpha_next = 8'd0;
            lkm_pkg::REGION_LOW_RAMP:  alpha_next = lkm_pkg::ALPHA_MAX - quo;
            lkm_pkg::REGION_HIGH_RAMP: alpha_next = quo;
            default:                   alpha_next = lkm_pkg::ALPHA_MAX;
        endcase
        if (invert_reg)
        begin
            alpha_next = lkm_pkg::ALPHA_MAX - alpha_next;
        end
    end

    // Stages 12 to 14: opacity product, rounded numerator, reciprocal product.
    assign prod_next = 16'(alpha_reg) * 16'(opacity_reg);
    assign x_next    = (24'(prod_reg) << 8) + lkm_pkg::WEIGHT_ROUND;
    assign xm_next   = 34'(x_reg) * 34'(lkm_pkg::RECIP_LOW);

    // Stage 15: quotient estimate, at most one below the true quotient.
    always_comb
    begin
        logic [40:0] recip_sum;
        recip_sum = (41'(x2_reg) << 16) + 41'(xm_reg);
        qest_next = recip_sum[40:32];
    end

    // Stage 16: remainder of the estimate, q * 65025 = q * 2^16 - q * 2^9 + q.
    always_comb
    begin
        logic [24:0] qm;
        logic [24:0] diff;
        qm         = (25'(qest_reg) << 16) - (25'(qest_reg) << 9) + 25'(qest_reg);
        diff       = 25'(x3_reg) - qm;
        rem_w_next = diff[16:0];
    end

    // Stage 17: correct the estimate by one where the remainder allows.
    assign weight_next = (rem_w_reg >= lkm_pkg::WEIGHT_DIV) ? q4_reg + 9'd1 : q4_reg;

    always_ff @(posedge clk)
    begin
        alpha_reg  <= alpha_next;
        prod_reg   <= prod_next;
        x_reg      <= x_next;
        x2_reg     <= x_reg;
        xm_reg     <= xm_next;
        x3_reg     <= x2_reg;
        qest_reg   <= qest_next;
        q4_reg     <= qest_reg;
        rem_w_reg  <= rem_w_next;
        weight_reg <= weight_next;
    end

    // Blend one component: (f * w + b * (256 - w) + 128) >> 8.
    function automatic logic [7:0] mix_comp(input logic [7:0] f, input logic [7:0] b,
                                            input logic [8:0] w);
        logic [16:0] acc;
        acc = 17'(f) * 17'(w) + 17'(b) * 17'(lkm_pkg::WEIGHT_ONE - w) + lkm_pkg::MIX_ROUND;
        return acc[15:8];
    endfunction

    // Stage 18: blend the three components into the output register.
    always_comb
    begin
        lkm_pkg::pixel_t p;
        p = pix_reg[ST_MIX-1];
        result_next.out_luma      = mix_comp(p.fg_luma, p.bg_luma, weight_reg);
        result_next.out_blue_diff = mix_comp(p.fg_blue_diff, p.bg_blue_diff, weight_reg);
        result_next.out_red_diff  = mix_comp(p.fg_red_diff, p.bg_red_diff, weight_reg);
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // A valid transaction leaves the last divider stage on one of the ramps.
    assign div_in_ramp = valid_reg[ST_ALPHA-1] &&
                         (div_region_reg[DIV_STEPS-1] inside
                          {lkm_pkg::REGION_LOW_RAMP, lkm_pkg::REGION_HIGH_RAMP});

    // Every accepted pixel yields exactly one result, and no result appears without one.
    `LKM_ASSERT_DELAY(a_result_follows, accept, LATENCY, done)
    `LKM_ASSERT_DELAY(a_no_spurious_result, !accept, LATENCY, !done)
    // The ramp divider leaves a remainder below the divisor.
    `LKM_ASSERT_IMPLY(a_div_remainder, div_in_ramp, div_rem_reg[DIV_STEPS-1] < 17'(softness_reg))
    // The corrected weight never exceeds full foreground.
    `LKM_ASSERT_IMPLY(a_weight_range, valid_reg[ST_WEIGHT], weight_reg <= lkm_pkg::WEIGHT_ONE)

endmodule

@@ bench/luma_key_mixer_core_tb.sv @@
// Self-checking bench for luma_key_mixer_core: directed pixels, then random phases.
// Depends on lkm_pkg; a scoreboard class predicts every mixed pixel.
module luma_key_mixer_core_tb;

    // Pipeline latency used by settle, and sender idle rates in percent.
    localparam int LATENCY    = 19;
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_HEAVY = 47;
    localparam int IDLE_LIGHT = 13;
    localparam int PHASES     = 12;
    localparam int PHASE_ITEMS = 130;

    // Scoreboard: mirrors the registers, predicts the blend and checks results.
    class key_mix_checker;
        bit [7:0] opacity;
        bit [7:0] low_thr;
        bit [7:0] high_thr;
        bit [7:0] softness;
        bit       invert;
        lkm_pkg::result_t pending_mix[$];
        int unsigned errors;

        function new();
            opacity  = lkm_pkg::OPACITY_RESET;
            low_thr  = lkm_pkg::LOW_THRESHOLD_RESET;
            high_thr = lkm_pkg::HIGH_THRESHOLD_RESET;
            softness = lkm_pkg::SOFTNESS_RESET;
            invert   = lkm_pkg::INVERT_KEY_RESET;
            errors   = 0;
        endfunction

        // Mirror of one register write; unknown indexes are dropped.
        function void update_reg(logic [lkm_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [lkm_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lkm_pkg::REG_OPACITY:        opacity  = data;
                lkm_pkg::REG_LOW_THRESHOLD:  low_thr  = data;
                lkm_pkg::REG_HIGH_THRESHOLD: high_thr = data;
                lkm_pkg::REG_SOFTNESS:       softness = data;
                lkm_pkg::REG_INVERT_KEY:     invert   = data[0];
                default: ;
            endcase
        endfunction

        // Key alpha from the foreground luma, with soft ramps on both sides.
        function int unsigned luma_alpha(int unsigned y);
            int unsigned lo;
            int unsigned hi;
            int unsigned s;
            int unsigned a;
            int unsigned d;
            lo = (low_thr < high_thr) ? low_thr : high_thr;
            hi = (low_thr < high_thr) ? high_thr : low_thr;
            s  = softness;
            if (y >= lo && y <= hi) begin
                a = 0;
            end
            else if (s > 0 && y < lo && y + s >= lo) begin
                d = y + s - lo;
                a = 255 - ((d * 255 + (s >> 1)) / s);
            end
            else if (s > 0 && y > hi && y <= hi + s) begin
                d = y - hi;
                a = (d * 255 + (s >> 1)) / s;
            end
            else begin
                a = 255;
            end
            if (a > 255)
                a = 255;
            if (invert)
                a = 255 - a;
            return a;
        endfunction

        // One component blended with weight w out of 256, rounded.
        function bit [7:0] blend(bit [7:0] f, bit [7:0] b, int unsigned w);
            int unsigned v;
            v = f * w + b * (256 - w) + 128;
            return v[15:8];
        endfunction

        // An accepted pixel pair: predict its mixed pixel.
        function void note_pixel(lkm_pkg::pixel_t p);
            int unsigned w;
            lkm_pkg::result_t r;
            w = (luma_alpha(p.fg_luma) * opacity * 256 + 32512) / 65025;
            r.out_luma      = blend(p.fg_luma, p.bg_luma, w);
            r.out_blue_diff = blend(p.fg_blue_diff, p.bg_blue_diff, w);
            r.out_red_diff  = blend(p.fg_red_diff, p.bg_red_diff, w);
            pending_mix.push_back(r);
        endfunction

        function int pending();
            return pending_mix.size();
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        // A result from the block: compare it with the oldest prediction.
        task check_mix(lkm_pkg::result_t r);
            lkm_pkg::result_t e;
            if (pending_mix.size() == 0) begin
                flag_mismatch("result arrived with no pixel in flight");
            end
            else begin
                e = pending_mix.pop_front();
                if (r.out_luma !== e.out_luma)
                    flag_mismatch($sformatf("out_luma %0d, expected %0d",
                                            r.out_luma, e.out_luma));
                if (r.out_blue_diff !== e.out_blue_diff)
                    flag_mismatch($sformatf("out_blue_diff %0d, expected %0d",
                                            r.out_blue_diff, e.out_blue_diff));
                if (r.out_red_diff !== e.out_red_diff)
                    flag_mismatch($sformatf("out_red_diff %0d, expected %0d",
                                            r.out_red_diff, e.out_red_diff));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    lkm_pkg::pixel_t pixel = '0;
    logic done;
    lkm_pkg::result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [lkm_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [lkm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    key_mix_checker chk;

    luma_key_mixer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pixel     (pixel),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a period of four time units.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Monitor: results are checked before the pixel taken at the same edge is noted.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                chk.check_mix(result);
            if (start && !busy)
                chk.note_pixel(pixel);
            if (cfg_valid && cfg_ready)
                chk.update_reg(cfg_index, cfg_data);
        end
    end

    // Drive one pixel pair after a random idle gap and wait for its transaction.
    task drive_pixel(input lkm_pkg::pixel_t p, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        pixel <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and wait until every predicted pixel has come back.
    task settle();
        start <= 1'b0;
        while (chk.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // One register write transaction, after which cfg_valid is dropped before the task returns.
    task cfg_write(input logic [lkm_pkg::CFG_INDEX_W-1:0] idx,
                   input logic [lkm_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Write every register while idle; invert_key gets junk upper bits and
    // an index past the register list is written too.
    task apply_setting(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi,
                       input logic [7:0] ramp_width, input logic inv);
        settle();
        cfg_write(lkm_pkg::REG_OPACITY, op);
        cfg_write(lkm_pkg::REG_LOW_THRESHOLD, lo);
        cfg_write(lkm_pkg::REG_HIGH_THRESHOLD, hi);
        cfg_write(lkm_pkg::REG_SOFTNESS, ramp_width);
        cfg_write(lkm_pkg::REG_INVERT_KEY, {7'($urandom_range(127)), inv});
        cfg_write(3'($urandom_range(7, int'(lkm_pkg::REG_INVERT_KEY) + 1)),
                  8'($urandom_range(255)));
    endtask

    // Directed pixel: chroma at the given extremes, luma chosen by the caller.
    task directed_pixel(input logic [7:0] y, input logic [7:0] fg_c, input logic [7:0] bg_c);
        lkm_pkg::pixel_t p;
        p.fg_luma      = y;
        p.fg_blue_diff = fg_c;
        p.fg_red_diff  = ~fg_c;
        p.bg_luma      = bg_c;
        p.bg_blue_diff = ~bg_c;
        p.bg_red_diff  = bg_c;
        drive_pixel(p, IDLE_NONE);
    endtask

    // One random phase: a setting, then pixels whose luma lands near the key window in half of the cases.
    task run_phase(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi,
                   input logic [7:0] ramp_width, input logic inv, input int count,
                   input int idle_pct);
        int t1;
        int t2;
        int lo_edge;
        int hi_edge;
        lkm_pkg::pixel_t p;
        apply_setting(op, lo, hi, ramp_width, inv);
        t1 = (lo < hi) ? lo : hi;
        t2 = (lo < hi) ? hi : lo;
        lo_edge = (t1 > ramp_width) ? t1 - ramp_width : 0;
        hi_edge = (t2 + ramp_width > 255) ? 255 : t2 + ramp_width;
        for (int i = 0; i < count; i++) begin
            p.fg_blue_diff = 8'($urandom_range(255));
            p.fg_red_diff  = 8'($urandom_range(255));
            p.bg_luma      = 8'($urandom_range(255));
            p.bg_blue_diff = 8'($urandom_range(255));
            p.bg_red_diff  = 8'($urandom_range(255));
            if ($urandom_range(1) == 0)
                p.fg_luma = 8'($urandom_range(255));
            else
                p.fg_luma = 8'($urandom_range(hi_edge, lo_edge));
            drive_pixel(p, idle_pct);
        end
    endtask

    // Stimulus: directed part at reset and a few hand-picked settings, then random phases.
    initial
    begin
        int idle_pct;
        chk = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: window 0..50, ramp of 20 above it.
        directed_pixel(8'd0, 8'hFF, 8'h00);
        directed_pixel(8'd50, 8'h00, 8'hFF);
        directed_pixel(8'd51, 8'hFF, 8'h00);
        directed_pixel(8'd60, 8'hFF, 8'h00);
        directed_pixel(8'd70, 8'h00, 8'hFF);
        directed_pixel(8'd71, 8'hFF, 8'h00);
        directed_pixel(8'd255, 8'hFF, 8'hFF);

        // Swapped thresholds, hard edges, inverted key, half opacity.
        apply_setting(8'd128, 8'd200, 8'd100, 8'd0, 1'b1);
        directed_pixel(8'd99, 8'hFF, 8'h00);
        directed_pixel(8'd100, 8'hFF, 8'h00);
        directed_pixel(8'd150, 8'h00, 8'hFF);
        directed_pixel(8'd200, 8'hFF, 8'h00);
        directed_pixel(8'd201, 8'h00, 8'hFF);
        directed_pixel(8'd0, 8'hFF, 8'h00);

        // Widest softness: both ramps run past the ends of the luma range.
        apply_setting(8'd255, 8'd10, 8'd245, 8'd255, 1'b0);
        directed_pixel(8'd0, 8'hFF, 8'h00);
        directed_pixel(8'd9, 8'hFF, 8'h00);
        directed_pixel(8'd246, 8'hFF, 8'h00);
        directed_pixel(8'd255, 8'h00, 8'hFF);

        // Zero opacity: background only, whatever the key says.
        apply_setting(8'd0, 8'd60, 8'd90, 8'd30, 1'b1);
        directed_pixel(8'd70, 8'hFF, 8'h00);
        directed_pixel(8'd0, 8'hFF, 8'h00);
        directed_pixel(8'd255, 8'h00, 8'hFF);

        // Random phases: extreme settings first, then random ones, with varied idling.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: idle_pct = IDLE_NONE;
                1: idle_pct = IDLE_HEAVY;
                2: idle_pct = IDLE_NONE;
                default: idle_pct = IDLE_LIGHT;
            endcase
            case (ph)
                0: run_phase(8'd255, 8'd0, 8'd50, 8'd20, 1'b0, PHASE_ITEMS, idle_pct);
                1: run_phase(8'd0, 8'd255, 8'd0, 8'd255, 1'b1, PHASE_ITEMS, idle_pct);
                2: run_phase(8'd255, 8'd128, 8'd128, 8'd0, 1'b0, PHASE_ITEMS, idle_pct);
                3: run_phase(8'd1, 8'd0, 8'd255, 8'd1, 1'b1, PHASE_ITEMS, idle_pct);
                4: run_phase(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, PHASE_ITEMS, idle_pct);
                5: run_phase(8'd200, 8'd30, 8'd220, 8'd0, 1'b1, PHASE_ITEMS, idle_pct);
                default: run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255)), 8'($urandom_range(255)),
                                   1'($urandom_range(1)), PHASE_ITEMS, idle_pct);
            endcase
        end

        settle();
        if (chk.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung run.
    initial
    begin
        #400000;
        $display("FAIL");
        $finish;
    end

endmodule
